FILE: rtl/core/assert_macros.svh
// assertion macros shared by the rtl that checks itself
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define IQAD_ASSERT_IMP(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("iqad assertion failed");

// next-cycle implication
`define IQAD_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("iqad assertion failed");

`endif

FILE: rtl/core/iqad_pkg.sv
// shared widths, codes, tables and helpers of the iq audio demodulator
// no dependencies
package iqad_pkg;

  localparam int SAMP_W  = 16;
  localparam int AUD_W   = 18;
  localparam int MODE_W  = 3;
  localparam int ALPHA_W = 16;
  localparam int FACT_W  = 7;
  localparam int CFG_DW  = 32;
  localparam int CFG_AW  = 4;
  localparam int WIDE_W  = 40;
  localparam int CORD_N  = 20;
  localparam int CORD_W  = 52;
  localparam int Z_W     = 24;
  localparam int K_W     = 5;
  localparam int MAX_DECIMATION_DEF = 64;

  localparam logic [MODE_W-1:0] MODE_AM  = 3'd0;
  localparam logic [MODE_W-1:0] MODE_NFM = 3'd1;
  localparam logic [MODE_W-1:0] MODE_WFM = 3'd2;
  localparam logic [MODE_W-1:0] MODE_USB = 3'd3;
  localparam logic [MODE_W-1:0] MODE_LSB = 3'd4;
  localparam logic [MODE_W-1:0] MODE_RAW = 3'd5;

  typedef logic [1:0] reg_idx_t;
  localparam reg_idx_t REG_DEMOD_MODE = 2'd0;
  localparam reg_idx_t REG_LPF_ALPHA  = 2'd1;
  localparam reg_idx_t REG_DC_ALPHA   = 2'd2;
  localparam reg_idx_t REG_DECIM      = 2'd3;

  localparam logic [MODE_W-1:0]  RST_DEMOD_MODE = MODE_AM;
  localparam logic [ALPHA_W-1:0] RST_LPF_ALPHA  = 16'd65535;
  localparam logic [ALPHA_W-1:0] RST_DC_ALPHA   = 16'd65208;
  localparam logic [FACT_W-1:0]  RST_DECIM      = 7'd1;

  localparam logic signed [Z_W-1:0] HALF_PI_U = 24'sd1647099;

  // arctan(2^-k) in units of 2^-20 rad
  function automatic logic signed [Z_W-1:0] atan_lut(input logic [K_W-1:0] k);
    logic signed [Z_W-1:0] v;
    case (k)
      5'd0:    v = 24'sd823550;
      5'd1:    v = 24'sd486170;
      5'd2:    v = 24'sd256879;
      5'd3:    v = 24'sd130396;
      5'd4:    v = 24'sd65451;
      5'd5:    v = 24'sd32757;
      5'd6:    v = 24'sd16383;
      5'd7:    v = 24'sd8192;
      5'd8:    v = 24'sd4096;
      5'd9:    v = 24'sd2048;
      5'd10:   v = 24'sd1024;
      5'd11:   v = 24'sd512;
      5'd12:   v = 24'sd256;
      5'd13:   v = 24'sd128;
      5'd14:   v = 24'sd64;
      5'd15:   v = 24'sd32;
      5'd16:   v = 24'sd16;
      5'd17:   v = 24'sd8;
      5'd18:   v = 24'sd4;
      5'd19:   v = 24'sd2;
      default: v = 24'sd0;
    endcase
    return v;
  endfunction

  // clamp to the q3.14 audio range
  function automatic logic signed [AUD_W-1:0] sat_aud(input logic signed [WIDE_W-1:0] v);
    logic signed [AUD_W-1:0] r;
    if (v > 40'sd131071) begin
      r = 18'sd131071;
    end else if (v < -40'sd131072) begin
      r = -18'sd131072;
    end else begin
      r = v[AUD_W-1:0];
    end
    return r;
  endfunction

endpackage

FILE: rtl/core/iqad_in_if.sv
// input channel: one iq sample with block-start flag per transaction
// depends on iqad_pkg
interface iqad_in_if;
  import iqad_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [SAMP_W-1:0] i_sample;
  logic signed [SAMP_W-1:0] q_sample;
  logic                     block_start;

  modport source (output valid, i_sample, q_sample, block_start, input ready);
  modport sink   (input valid, i_sample, q_sample, block_start, output ready);
endinterface

FILE: rtl/core/iqad_out_if.sv
// result channel: one decimated audio sample per transaction
// depends on iqad_pkg
interface iqad_out_if;
  import iqad_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [AUD_W-1:0] audio_sample;

  modport source (output valid, audio_sample, input ready);
  modport sink   (input valid, audio_sample, output ready);
endinterface

FILE: rtl/core/iq_audio_demodulator_core.sv
// iq audio demodulator: one sample in, zero or one decimated audio sample out
// processing: ssb/raw go straight to the filters, am adds a 16-step square root, fm a
// 20-step cordic, and a bit-serial divide runs when a group closes
// throughput: one transaction at a time, the sequencer sets the rate; input not ready
// until the previous sample has finished; output register decouples the result side
// reset: synchronous active-low, loads register defaults and zeros all filter state
`include "assert_macros.svh"

module iq_audio_demodulator_core #(
  parameter int MAX_DECIMATION = iqad_pkg::MAX_DECIMATION_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  iqad_in_if.sink                     in_if,
  iqad_out_if.source                  out_if,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [iqad_pkg::CFG_AW-1:0] paddr,
  input  logic [iqad_pkg::CFG_DW-1:0] pwdata,
  output logic [iqad_pkg::CFG_DW-1:0] prdata,
  output logic                        pready
);
  import iqad_pkg::*;

  // decimation sizing follows the largest factor
  localparam int CNT_W    = $clog2(MAX_DECIMATION + 1);
  localparam int SUM_W    = AUD_W + $clog2(MAX_DECIMATION);
  localparam int DVD_W    = SUM_W;
  localparam int REM_W    = CNT_W + 1;
  localparam int STEP_MAX = (CORD_N + 1 > DVD_W) ? CORD_N + 1 : DVD_W;
  localparam int STEP_W   = $clog2(STEP_MAX + 1);
  // square root and multiplier sizing
  localparam int SQRT_N   = SAMP_W;
  localparam int N_W      = 2 * SAMP_W;
  localparam int SREM_W   = SAMP_W + 3;
  localparam int ACC_W    = 2 * SAMP_W + 2;
  localparam int MA_W     = AUD_W + 1;
  localparam int MB_W     = AUD_W;
  localparam int PROD_W   = MA_W + MB_W;

  typedef enum logic [9:0] {
    ST_IDLE    = 10'b0000000001,
    ST_PROD    = 10'b0000000010,
    ST_SQRT    = 10'b0000000100,
    ST_CORD    = 10'b0000001000,
    ST_LPF_MUL = 10'b0000010000,
    ST_LPF_ADD = 10'b0000100000,
    ST_DC_MUL  = 10'b0001000000,
    ST_DC_ADD  = 10'b0010000000,
    ST_DIV     = 10'b0100000000,
    ST_EMIT    = 10'b1000000000
  } state_t;

  // control and architectural state
  state_t                    state_r, state_nxt;
  logic [STEP_W-1:0]         step_r, step_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic [MODE_W-1:0]         demod_mode_r, demod_mode_nxt;
  logic [ALPHA_W-1:0]        lpf_alpha_r, lpf_alpha_nxt;
  logic [ALPHA_W-1:0]        dc_alpha_r, dc_alpha_nxt;
  logic [FACT_W-1:0]         decim_r, decim_nxt;
  logic signed [SAMP_W-1:0]  prev_i_r, prev_i_nxt;
  logic signed [SAMP_W-1:0]  prev_q_r, prev_q_nxt;
  logic signed [AUD_W-1:0]   lp_r, lp_nxt;
  logic signed [AUD_W-1:0]   dc_in_r, dc_in_nxt;
  logic signed [AUD_W-1:0]   dc_out_r, dc_out_nxt;
  logic signed [SUM_W-1:0]   decim_sum_r, decim_sum_nxt;
  logic [CNT_W-1:0]          decim_cnt_r, decim_cnt_nxt;

  // working payload
  logic signed [SAMP_W-1:0]  si_r, si_nxt;
  logic signed [SAMP_W-1:0]  sq_r, sq_nxt;
  logic                      start_r, start_nxt;
  logic signed [AUD_W-1:0]   x_r, x_nxt;
  logic signed [ACC_W-1:0]   re_r, re_nxt;
  logic signed [ACC_W-1:0]   im_r, im_nxt;
  logic [N_W-1:0]            n_r, n_nxt;
  logic [SREM_W-1:0]         srem_r, srem_nxt;
  logic [SAMP_W-1:0]         root_r, root_nxt;
  logic signed [CORD_W-1:0]  cx_r, cx_nxt;
  logic signed [CORD_W-1:0]  cy_r, cy_nxt;
  logic signed [Z_W-1:0]     cz_r, cz_nxt;
  logic                      neg_r, neg_nxt;
  logic [DVD_W-1:0]          quo_r, quo_nxt;
  logic [REM_W-1:0]          drem_r, drem_nxt;
  logic [CNT_W-1:0]          f_r, f_nxt;
  logic signed [AUD_W-1:0]   out_data_r, out_data_nxt;
  logic signed [PROD_W-1:0]  prod_r;

  // shared multiplier operands
  logic signed [MA_W-1:0]    mul_a;
  logic signed [MB_W-1:0]    mul_b;
  logic signed [PROD_W-1:0]  mul_p;

  logic                      is_am, is_fm, lpf_on;
  logic [STEP_W-1:0]         n_prod;
  logic [CNT_W-1:0]          f_eff;
  logic                      cfg_wr;
  reg_idx_t                  cfg_idx;

  assign is_am  = (demod_mode_r == MODE_AM);
  assign is_fm  = (demod_mode_r == MODE_NFM) || (demod_mode_r == MODE_WFM);
  assign lpf_on = (demod_mode_r <= MODE_LSB);
  assign n_prod = is_fm ? STEP_W'(4) : STEP_W'(2);

  // zero acts as one, anything above the maximum acts as the maximum
  always_comb begin
    if (decim_r == '0) begin
      f_eff = CNT_W'(1);
    end else if (int'(decim_r) > MAX_DECIMATION) begin
      f_eff = CNT_W'(MAX_DECIMATION);
    end else begin
      f_eff = CNT_W'(decim_r);
    end
  end

  // apb register port
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = reg_idx_t'(paddr[CFG_AW-1:2]);

  always_comb begin
    case (cfg_idx)
      REG_DEMOD_MODE: prdata = CFG_DW'(demod_mode_r);
      REG_LPF_ALPHA:  prdata = CFG_DW'(lpf_alpha_r);
      REG_DC_ALPHA:   prdata = CFG_DW'(dc_alpha_r);
      REG_DECIM:      prdata = CFG_DW'(decim_r);
      default:        prdata = '0;
    endcase
  end

  // operand select for the one multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      ST_PROD: begin
        case (step_r[1:0])
          2'd0: begin
            mul_a = MA_W'(si_r);
            mul_b = is_fm ? MB_W'(prev_i_r) : MB_W'(si_r);
          end
          2'd1: begin
            mul_a = MA_W'(sq_r);
            mul_b = is_fm ? MB_W'(prev_q_r) : MB_W'(sq_r);
          end
          2'd2: begin
            mul_a = MA_W'(sq_r);
            mul_b = MB_W'(prev_i_r);
          end
          default: begin
            mul_a = MA_W'(si_r);
            mul_b = MB_W'(prev_q_r);
          end
        endcase
      end
      ST_LPF_MUL: begin
        mul_a = MA_W'(x_r) - MA_W'(lp_r);
        mul_b = MB_W'({2'b00, lpf_alpha_r});
      end
      ST_DC_MUL: begin
        mul_a = MA_W'(dc_out_r);
        mul_b = MB_W'({2'b00, dc_alpha_r});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

  // sequencer
  always_comb begin
    logic signed [SAMP_W:0]    ssb;
    logic signed [ACC_W-1:0]   pacc;
    logic [STEP_W-1:0]         pidx;
    logic [SREM_W-1:0]         srem_sh, strial;
    logic [K_W-1:0]            k;
    logic signed [CORD_W-1:0]  xs, ys, x0, y0;
    logic signed [AUD_W-1:0]   ly, dy;
    logic signed [SUM_W-1:0]   base_sum, sum_new;
    logic [CNT_W-1:0]          base_cnt, cnt_new;
    logic [DVD_W-1:0]          mag;
    logic [REM_W-1:0]          rsh;
    logic                      ge;
    logic signed [WIDE_W-1:0]  qs;

    state_nxt      = state_r;
    step_nxt       = step_r;
    out_valid_nxt  = out_valid_r && !out_if.ready;
    demod_mode_nxt = demod_mode_r;
    lpf_alpha_nxt  = lpf_alpha_r;
    dc_alpha_nxt   = dc_alpha_r;
    decim_nxt      = decim_r;
    prev_i_nxt     = prev_i_r;
    prev_q_nxt     = prev_q_r;
    lp_nxt         = lp_r;
    dc_in_nxt      = dc_in_r;
    dc_out_nxt     = dc_out_r;
    decim_sum_nxt  = decim_sum_r;
    decim_cnt_nxt  = decim_cnt_r;
    si_nxt         = si_r;
    sq_nxt         = sq_r;
    start_nxt      = start_r;
    x_nxt          = x_r;
    re_nxt         = re_r;
    im_nxt         = im_r;
    n_nxt          = n_r;
    srem_nxt       = srem_r;
    root_nxt       = root_r;
    cx_nxt         = cx_r;
    cy_nxt         = cy_r;
    cz_nxt         = cz_r;
    neg_nxt        = neg_r;
    quo_nxt        = quo_r;
    drem_nxt       = drem_r;
    f_nxt          = f_r;
    out_data_nxt   = out_data_r;

    ssb      = '0;
    pacc     = ACC_W'(prod_r);
    pidx     = step_r - 1'b1;
    srem_sh  = {srem_r[SREM_W-3:0], n_r[N_W-1 -: 2]};
    strial   = SREM_W'({root_r, 2'b01});
    k        = K_W'(step_r - 1'b1);
    xs       = cx_r >>> k;
    ys       = cy_r >>> k;
    x0       = CORD_W'(re_r) <<< 16;
    y0       = CORD_W'(im_r) <<< 16;
    ly       = '0;
    dy       = '0;
    base_sum = start_r ? '0 : decim_sum_r;
    base_cnt = start_r ? '0 : decim_cnt_r;
    sum_new  = '0;
    cnt_new  = '0;
    mag      = '0;
    rsh      = {drem_r[REM_W-2:0], quo_r[DVD_W-1]};
    ge       = (rsh >= REM_W'(f_r));
    qs       = neg_r ? -WIDE_W'(quo_r) : WIDE_W'(quo_r);

    if (cfg_wr) begin
      case (cfg_idx)
        REG_DEMOD_MODE: demod_mode_nxt = pwdata[MODE_W-1:0];
        REG_LPF_ALPHA:  lpf_alpha_nxt  = pwdata[ALPHA_W-1:0];
        REG_DC_ALPHA:   dc_alpha_nxt   = pwdata[ALPHA_W-1:0];
        REG_DECIM:      decim_nxt      = pwdata[FACT_W-1:0];
        default:        decim_nxt      = decim_r;
      endcase
    end

    case (state_r)
      ST_IDLE: begin
        if (in_if.valid) begin
          si_nxt    = in_if.i_sample;
          sq_nxt    = in_if.q_sample;
          start_nxt = in_if.block_start;
          step_nxt  = '0;
          re_nxt    = '0;
          im_nxt    = '0;
          case (demod_mode_r)
            MODE_USB: ssb = (SAMP_W+1)'(in_if.i_sample) - (SAMP_W+1)'(in_if.q_sample);
            MODE_LSB: ssb = (SAMP_W+1)'(in_if.i_sample) + (SAMP_W+1)'(in_if.q_sample);
            default:  ssb = (SAMP_W+1)'(in_if.i_sample);
          endcase
          x_nxt = AUD_W'(ssb >>> 1);
          if (is_am || is_fm) begin
            state_nxt = ST_PROD;
          end else begin
            state_nxt = ST_LPF_MUL;
          end
        end
      end

      // products issue on steps 0..n-1 and accumulate on the following step
      ST_PROD: begin
        if (step_r != '0) begin
          case (pidx[1:0])
            2'd0:    re_nxt = pacc;
            2'd1:    re_nxt = re_r + pacc;
            2'd2:    im_nxt = pacc;
            default: im_nxt = im_r - pacc;
          endcase
        end
        if (step_r == n_prod) begin
          step_nxt = '0;
          if (is_fm) begin
            prev_i_nxt = si_r;
            prev_q_nxt = sq_r;
            state_nxt  = ST_CORD;
          end else begin
            state_nxt  = ST_SQRT;
          end
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end

      // restoring square root, two radicand bits a step
      ST_SQRT: begin
        if (step_r == '0) begin
          n_nxt    = re_r[N_W-1:0];
          srem_nxt = '0;
          root_nxt = '0;
          step_nxt = step_r + 1'b1;
        end else begin
          n_nxt = n_r << 2;
          if (srem_sh >= strial) begin
            srem_nxt = srem_sh - strial;
            root_nxt = {root_r[SAMP_W-2:0], 1'b1};
          end else begin
            srem_nxt = srem_sh;
            root_nxt = {root_r[SAMP_W-2:0], 1'b0};
          end
          if (step_r == STEP_W'(SQRT_N)) begin
            x_nxt     = AUD_W'(root_nxt >> 1);
            step_nxt  = '0;
            state_nxt = ST_LPF_MUL;
          end else begin
            step_nxt = step_r + 1'b1;
          end
        end
      end

      // vectoring cordic: pre-rotate into the right half plane, then 20 steps
      ST_CORD: begin
        if (step_r == '0) begin
          if (re_r == '0 && im_r == '0) begin
            x_nxt     = '0;
            state_nxt = ST_LPF_MUL;
          end else begin
            if (x0 < 0) begin
              if (y0 >= 0) begin
                cx_nxt = y0;
                cy_nxt = -x0;
                cz_nxt = HALF_PI_U;
              end else begin
                cx_nxt = -y0;
                cy_nxt = x0;
                cz_nxt = -HALF_PI_U;
              end
            end else begin
              cx_nxt = x0;
              cy_nxt = y0;
              cz_nxt = '0;
            end
            step_nxt = step_r + 1'b1;
          end
        end else if (step_r == STEP_W'(CORD_N + 1)) begin
          x_nxt     = sat_aud((WIDE_W'(cz_r) + 40'sd32) >>> 6);
          step_nxt  = '0;
          state_nxt = ST_LPF_MUL;
        end else begin
          if (cy_r >= 0) begin
            cx_nxt = cx_r + ys;
            cy_nxt = cy_r - xs;
            cz_nxt = cz_r + atan_lut(k);
          end else begin
            cx_nxt = cx_r - ys;
            cy_nxt = cy_r + xs;
            cz_nxt = cz_r - atan_lut(k);
          end
          step_nxt = step_r + 1'b1;
        end
      end

      ST_LPF_MUL: state_nxt = ST_LPF_ADD;

      // single-pole low-pass, bypassed in raw mode and the unused mode codes, restarts at a block start
      ST_LPF_ADD: begin
        if (lpf_on) begin
          if (start_r) begin
            ly = x_r;
          end else begin
            ly = sat_aud(WIDE_W'(lp_r) + ((WIDE_W'(prod_r) + 40'sd32768) >>> 16));
          end
          lp_nxt = ly;
          x_nxt  = ly;
        end
        state_nxt = ST_DC_MUL;
      end

      ST_DC_MUL: state_nxt = ST_DC_ADD;

      // dc blocker, then group accumulate, starting the divide when a group closes
      ST_DC_ADD: begin
        dy = sat_aud(WIDE_W'(x_r) - WIDE_W'(dc_in_r)
                     + ((WIDE_W'(prod_r) + 40'sd32768) >>> 16));
        dc_in_nxt  = x_r;
        dc_out_nxt = dy;
        sum_new    = base_sum + SUM_W'(dy);
        cnt_new    = base_cnt + 1'b1;
        if (cnt_new < f_eff) begin
          decim_sum_nxt = sum_new;
          decim_cnt_nxt = cnt_new;
          state_nxt     = ST_IDLE;
        end else begin
          decim_sum_nxt = '0;
          decim_cnt_nxt = '0;
          neg_nxt       = (sum_new < 0);
          mag           = (sum_new < 0) ? DVD_W'(-sum_new) : DVD_W'(sum_new);
          quo_nxt       = mag + DVD_W'(f_eff >> 1);
          drem_nxt      = '0;
          f_nxt         = f_eff;
          step_nxt      = '0;
          state_nxt     = ST_DIV;
        end
      end

      // restoring divide of the rounded magnitude, one quotient bit a step
      ST_DIV: begin
        drem_nxt = ge ? (rsh - REM_W'(f_r)) : rsh;
        quo_nxt  = {quo_r[DVD_W-2:0], ge};
        if (step_r == STEP_W'(DVD_W - 1)) begin
          step_nxt  = '0;
          state_nxt = ST_EMIT;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end

      // wait for the output register to free up
      ST_EMIT: begin
        if (!out_valid_r || out_if.ready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = sat_aud(qs);
          state_nxt     = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      step_r       <= '0;
      out_valid_r  <= 1'b0;
      demod_mode_r <= RST_DEMOD_MODE;
      lpf_alpha_r  <= RST_LPF_ALPHA;
      dc_alpha_r   <= RST_DC_ALPHA;
      decim_r      <= RST_DECIM;
      prev_i_r     <= '0;
      prev_q_r     <= '0;
      lp_r         <= '0;
      dc_in_r      <= '0;
      dc_out_r     <= '0;
      decim_sum_r  <= '0;
      decim_cnt_r  <= '0;
    end else begin
      state_r      <= state_nxt;
      step_r       <= step_nxt;
      out_valid_r  <= out_valid_nxt;
      demod_mode_r <= demod_mode_nxt;
      lpf_alpha_r  <= lpf_alpha_nxt;
      dc_alpha_r   <= dc_alpha_nxt;
      decim_r      <= decim_nxt;
      prev_i_r     <= prev_i_nxt;
      prev_q_r     <= prev_q_nxt;
      lp_r         <= lp_nxt;
      dc_in_r      <= dc_in_nxt;
      dc_out_r     <= dc_out_nxt;
      decim_sum_r  <= decim_sum_nxt;
      decim_cnt_r  <= decim_cnt_nxt;
    end
  end

  // datapath registers, no reset needed
  always_ff @(posedge clk) begin
    si_r       <= si_nxt;
    sq_r       <= sq_nxt;
    start_r    <= start_nxt;
    x_r        <= x_nxt;
    re_r       <= re_nxt;
    im_r       <= im_nxt;
    n_r        <= n_nxt;
    srem_r     <= srem_nxt;
    root_r     <= root_nxt;
    cx_r       <= cx_nxt;
    cy_r       <= cy_nxt;
    cz_r       <= cz_nxt;
    neg_r      <= neg_nxt;
    quo_r      <= quo_nxt;
    drem_r     <= drem_nxt;
    f_r        <= f_nxt;
    out_data_r <= out_data_nxt;
    prod_r     <= mul_p;
  end

  assign in_if.ready         = (state_r == ST_IDLE);
  assign out_if.valid        = out_valid_r;
  assign out_if.audio_sample = out_data_r;

  // a taken sample always starts the sequencer
  `IQAD_ASSERT_NEXT(a_accept_busy, clk, rst_n, in_if.valid && in_if.ready, state_r != ST_IDLE)
  // the group count stays below the largest factor between samples
  `IQAD_ASSERT_IMP(a_cnt_range, clk, rst_n, 1'b1, decim_cnt_r < CNT_W'(MAX_DECIMATION))
  // divider remainder stays below the divisor
  `IQAD_ASSERT_IMP(a_div_rem, clk, rst_n, state_r == ST_DIV, drem_r < REM_W'(f_r))
  // a result only appears out of the emit step
  `IQAD_ASSERT_IMP(a_out_src, clk, rst_n, $rose(out_valid_r), $past(state_r) == ST_EMIT)

endmodule

FILE: tb/iq_audio_demodulator_core_tb.sv
// self-checking testbench for the iq audio demodulator core
// depends on iqad_pkg, iqad_in_if, iqad_out_if and the core rtl
`timescale 1ns / 100ps

module iq_audio_demodulator_core_tb;
  import iqad_pkg::*;

  logic clk;
  logic rst_n;
  logic psel, penable, pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [CFG_DW-1:0] pwdata;
  logic [CFG_DW-1:0] prdata;
  logic pready;

  iqad_in_if  in_ch ();
  iqad_out_if out_ch ();

  iq_audio_demodulator_core dut (
    .clk(clk), .rst_n(rst_n), .in_if(in_ch.sink), .out_if(out_ch.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // predictor copy of the configuration and filter state
  logic [MODE_W-1:0]  cur_mode;
  logic [ALPHA_W-1:0] cur_lpf;
  logic [ALPHA_W-1:0] cur_dca;
  logic [FACT_W-1:0]  cur_fact;
  longint hist_i, hist_q, lp_state, dc_in_state, dc_out_state, grp_sum, grp_cnt;

  logic signed [AUD_W-1:0] audio_q[$];
  int err_count;
  bit idle_en;

  localparam longint ATAN_K[20] = '{823550, 486170, 256879, 130396, 65451, 32757,
    16383, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32, 16, 8, 4, 2};
  localparam longint HALF_PI = 1647099;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // floor shift for negative values too
  function automatic longint fshr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint clamp_aud(longint v);
    if (v > 131071) return 131071;
    if (v < -131072) return -131072;
    return v;
  endfunction

  function automatic longint int_sqrt(longint n);
    longint r, b;
    r = 0;
    b = 64'sd1 <<< 62;
    while (b > n) b = b >>> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >>> 1) + b;
      end else begin
        r = r >>> 1;
      end
      b = b >>> 2;
    end
    return r;
  endfunction

  // vectoring cordic, angle in units of 2^-20 rad then to q3.14
  function automatic longint phase_step(longint re, longint im);
    longint x, y, z, t, xs, ys;
    x = re * 65536;
    y = im * 65536;
    z = 0;
    if (re == 0 && im == 0) return 0;
    if (x < 0) begin
      if (y >= 0) begin
        t = x; x = y; y = -t; z = HALF_PI;
      end else begin
        t = x; x = -y; y = t; z = -HALF_PI;
      end
    end
    for (int k = 0; k < 20; k++) begin
      xs = x >>> k;
      ys = y >>> k;
      if (y >= 0) begin
        x = x + ys; y = y - xs; z = z + ATAN_K[k];
      end else begin
        x = x - ys; y = y + xs; z = z - ATAN_K[k];
      end
    end
    return clamp_aud((z + 32) >>> 6);
  endfunction

  // advance the predicted pipeline by one sample, queue audio when a group closes
  task automatic predict_audio(logic signed [15:0] si_v, logic signed [15:0] sq_v, bit bs);
    longint si, sq, x, y, f, mag, qv;
    si = si_v;
    sq = sq_v;
    case (cur_mode)
      MODE_AM: x = int_sqrt(si * si + sq * sq) >>> 1;
      MODE_NFM, MODE_WFM: begin
        x = phase_step(si * hist_i + sq * hist_q, sq * hist_i - si * hist_q);
        hist_i = si;
        hist_q = sq;
      end
      MODE_USB: x = fshr(si - sq, 1);
      MODE_LSB: x = fshr(si + sq, 1);
      default:  x = fshr(si, 1);
    endcase
    if (cur_mode <= MODE_LSB) begin
      if (bs) y = x;
      else y = lp_state + fshr((x - lp_state) * longint'(cur_lpf) + 32768, 16);
      y = clamp_aud(y);
      lp_state = y;
      x = y;
    end
    y = clamp_aud(x - dc_in_state + fshr(dc_out_state * longint'(cur_dca) + 32768, 16));
    dc_in_state = x;
    dc_out_state = y;
    if (bs) begin
      grp_sum = 0;
      grp_cnt = 0;
    end
    f = cur_fact;
    if (f < 1) f = 1;
    if (f > MAX_DECIMATION_DEF) f = MAX_DECIMATION_DEF;
    grp_sum += y;
    grp_cnt++;
    if (grp_cnt >= f) begin
      mag = grp_sum < 0 ? -grp_sum : grp_sum;
      qv = (mag + f / 2) / f;
      if (grp_sum < 0) qv = -qv;
      grp_sum = 0;
      grp_cnt = 0;
      audio_q.push_back(clamp_aud(qv));
    end
  endtask

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
    err_count++;
  endtask

  // apb write, setup then access phase; predictor updated at the same time
  task automatic cfg_write(reg_idx_t idx, logic [CFG_DW-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CFG_AW'(idx) << 2;
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_DEMOD_MODE: cur_mode = val[MODE_W-1:0];
      REG_LPF_ALPHA:  cur_lpf  = val[ALPHA_W-1:0];
      REG_DC_ALPHA:   cur_dca  = val[ALPHA_W-1:0];
      default:        cur_fact = val[FACT_W-1:0];
    endcase
    // bus idle between transfers
    @(posedge clk);
  endtask

  // one input transaction, sometimes with a random gap ahead of it; valid stays up after
  // the accept while the core is busy and is dropped by the next gap or drain
  task automatic send_sample(logic signed [15:0] si, logic signed [15:0] sq, bit bs);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.i_sample    <= si;
    in_ch.q_sample    <= sq;
    in_ch.block_start <= bs;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predict_audio(si, sq, bs);
  endtask

  // wait for the block to go idle before touching registers
  task automatic drain_pipe();
    int guard;
    guard = 0;
    in_ch.valid <= 1'b0;
    while (audio_q.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    // a sample that closes no group may still be in flight
    repeat (120) @(posedge clk);
  endtask

  function automatic logic signed [15:0] rand_samp();
    case ($urandom_range(0, 7))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return 16'sh0000;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic apply_cfg(logic [2:0] m, logic [15:0] la, logic [15:0] da, logic [6:0] df);
    cfg_write(REG_DEMOD_MODE, 32'(m));
    cfg_write(REG_LPF_ALPHA, 32'(la));
    cfg_write(REG_DC_ALPHA, 32'(da));
    cfg_write(REG_DECIM, 32'(df));
  endtask

  // directed: field extremes in every mode, zero fm product, odd modes
  task automatic test_directed();
    logic [2:0] m;
    for (int mi = 0; mi < 8; mi++) begin
      m = 3'(mi);
      apply_cfg(m, (mi == 7) ? 16'd0 : 16'hffff, 16'hffff, 7'd1);
      send_sample(16'sh7fff, 16'sh8000, 1'b1);
      send_sample(16'sh8000, 16'sh8000, 1'b0);
      send_sample(16'sh0000, 16'sh0000, 1'b0);
      drain_pipe();
    end
    // fm with a zero product after a zero sample, then rotation
    apply_cfg(MODE_NFM, 16'd40000, 16'd0, 7'd0);
    send_sample(16'sh0000, 16'sh0000, 1'b1);
    send_sample(16'sh4000, 16'sh0000, 1'b0);
    send_sample(16'sh0000, 16'sh4000, 1'b0);
    send_sample(-16'sh4000, 16'sh0000, 1'b0);
    drain_pipe();
  endtask

  // group closing and partial groups dropped at block start, extreme factors
  task automatic test_decimation();
    apply_cfg(MODE_USB, 16'd30000, 16'd65208, 7'd64);
    for (int n = 0; n < 70; n++) send_sample(rand_samp(), rand_samp(), n == 0 || n == 40);
    drain_pipe();
    cfg_write(REG_DECIM, 32'd127);
    for (int n = 0; n < 70; n++) send_sample(rand_samp(), rand_samp(), n == 0);
    drain_pipe();
    cfg_write(REG_DECIM, 32'd3);
    for (int n = 0; n < 20; n++) send_sample(rand_samp(), rand_samp(), $urandom_range(0, 9) == 0);
    drain_pipe();
  endtask

  // random phases with random settings, mostly small factors
  task automatic test_random(int phases, int per_phase);
    logic [6:0] df;
    for (int p = 0; p < phases; p++) begin
      df = ($urandom_range(0, 9) == 0) ? 7'($urandom) : 7'($urandom_range(1, 4));
      apply_cfg(3'($urandom), 16'($urandom), 16'($urandom), df);
      for (int n = 0; n < per_phase; n++)
        send_sample(rand_samp(), rand_samp(), n == 0 || $urandom_range(0, 30) == 0);
      drain_pipe();
    end
  endtask

  // result side: random back-pressure and comparison against the oldest expectation
  initial begin
    logic signed [AUD_W-1:0] want;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (idle_en && $urandom_range(0, 3) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        if (audio_q.size() == 0) begin
          report_mismatch("unexpected audio transaction", out_ch.audio_sample, 0);
        end else begin
          want = audio_q.pop_front();
          if (out_ch.audio_sample !== want)
            report_mismatch("audio_sample", out_ch.audio_sample, want);
        end
      end
    end
  end

  initial begin
    #50ms;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    err_count = 0;
    idle_en = 1'b1;
    rst_n = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    in_ch.valid = 1'b0; in_ch.i_sample = '0; in_ch.q_sample = '0; in_ch.block_start = 1'b0;
    cur_mode = RST_DEMOD_MODE; cur_lpf = RST_LPF_ALPHA;
    cur_dca = RST_DC_ALPHA; cur_fact = RST_DECIM;
    hist_i = 0; hist_q = 0; lp_state = 0; dc_in_state = 0; dc_out_state = 0;
    grp_sum = 0; grp_cnt = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_decimation();
    test_random(20, 80);
    // final stretch without idling
    idle_en = 1'b0;
    test_random(2, 60);
    drain_pipe();
    if (err_count == 0 && audio_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+rtl/core
rtl/core/iqad_pkg.sv
rtl/core/iqad_in_if.sv
rtl/core/iqad_out_if.sv
rtl/core/iq_audio_demodulator_core.sv
tb/iq_audio_demodulator_core_tb.sv
